// File: src/idgs_pkg.sv
package idgs_pkg;

	// mesh and sweep limits
	localparam int MAX_POINTS = 64;
	localparam int PT_W       = 6;
	localparam int CNT_W      = 7;
	localparam int MAX_SWEEPS = 5;
	localparam int SWEEP_W    = 3;

	// field and register widths
	localparam int VAL_W   = 32;
	localparam int SIGMA_W = 32;
	localparam int THETA_W = 17;
	localparam int COEF_W  = 35;
	localparam int NUM_W   = 40;
	localparam int WIDE_W  = 48;
	localparam int CFG_IDX_W = 2;

	// fixed-point constants
	localparam logic [THETA_W-1:0] THETA_ONE  = 17'd65536;
	localparam logic [CNT_W-1:0]   MIN_POINTS = 7'd3;
	localparam logic [CNT_W-1:0]   TOP_POINTS = 7'd64;
	localparam logic [COEF_W-1:0]  ONE_Q24    = 35'd16777216;
	localparam logic [63:0]        CONV_LIMIT = 64'd4294;
	localparam logic signed [WIDE_W-1:0] NUM_LIMIT = 48'sd274877906944;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIGMA  = 2'd0,
		REG_THETA  = 2'd1,
		REG_POINTS = 2'd2
	} cfg_reg_t;

	// input opcodes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} opcode_t;

	// multiply unit modes
	typedef enum logic {
		MAC_RAW = 1'b0,
		MAC_Q24 = 1'b1
	} mac_mode_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		if (v > 48'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -48'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		logic [32:0] t;
		t = v[31] ? (33'd0 - {v[31], v}) : {v[31], v};
		return t[31:0];
	endfunction

	function automatic logic [31:0] mag_clamp32(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] m;
		m = v[WIDE_W-1] ? (48'd0 - v) : v;
		return (m > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

endpackage

// File: src/implicit_diffusion_step_gauss_seidel.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: point_index, value
// m_*       out  m_tvalid/m_tready  tdata: out_index, velocity, residual; tlast: last
// cfg_*     in   cfg_wen            cfg_index, cfg_data
//
// A load transaction is taken only in the idle state. With m = n-2 interior points,
// each of the S sweeps run passes the 63-step divider once per interior point. The
// multiplier, divider and square root unit are each shared.
// Reset clears the velocity and correction stores through valid bits; no clearing pass is needed.
// s_tready is low for the whole step; each result waits in the output register
// until taken, and the next point is read only afterwards.
module implicit_diffusion_step_gauss_seidel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [5:0] point_index, [37:6] value, [39:38] zero
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [5:0] out_index, [37:6] velocity, [69:38] residual
	output logic        m_tlast,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import idgs_pkg::*;

	typedef enum logic [30:0] {
		ST_IDLE     = 31'h0000_0001,
		ST_TS_MUL   = 31'h0000_0002,
		ST_TS_WAIT  = 31'h0000_0004,
		ST_RHS_RD0  = 31'h0000_0008,
		ST_RHS_RD1  = 31'h0000_0010,
		ST_RHS_RD2  = 31'h0000_0020,
		ST_RHS_RD3  = 31'h0000_0040,
		ST_RHS_MUL  = 31'h0000_0080,
		ST_RHS_WAIT = 31'h0000_0100,
		ST_NB_RD0   = 31'h0000_0200,
		ST_NB_RD1   = 31'h0000_0400,
		ST_NB_RD2   = 31'h0000_0800,
		ST_NB_RD3   = 31'h0000_1000,
		ST_SW_MUL   = 31'h0000_2000,
		ST_SW_WMUL  = 31'h0000_4000,
		ST_SW_DIV   = 31'h0000_8000,
		ST_SW_WDIV  = 31'h0001_0000,
		ST_SW_SQ    = 31'h0002_0000,
		ST_SW_WSQ   = 31'h0004_0000,
		ST_UP_RD    = 31'h0008_0000,
		ST_UP_WR    = 31'h0010_0000,
		ST_RS_M1    = 31'h0020_0000,
		ST_RS_W1    = 31'h0040_0000,
		ST_RS_M2    = 31'h0080_0000,
		ST_RS_W2    = 31'h0100_0000,
		ST_RS_SQ    = 31'h0200_0000,
		ST_RS_WSQ   = 31'h0400_0000,
		ST_SQRT     = 31'h0800_0000,
		ST_EM_RD    = 31'h1000_0000,
		ST_EM_LD    = 31'h2000_0000,
		ST_EM_WAIT  = 31'h4000_0000
	} idgs_state_t;

	// configuration registers
	logic [SIGMA_W-1:0] sigma_q;
	logic [THETA_W-1:0] theta_q;
	logic [CNT_W-1:0]   points_q;

	// sequencer state
	idgs_state_t        st_q;
	logic [CNT_W-1:0]   n_q;
	logic [THETA_W-1:0] th_q;
	logic [32:0]        ts_q;
	logic [COEF_W-1:0]  diag_q;
	logic [PT_W-1:0]    i_q;
	logic [SWEEP_W-1:0] sweep_q;
	logic               resid_q;
	logic [63:0]        err_q;
	logic [63:0]        rsum_q;
	logic signed [34:0] acc_q;
	logic signed [31:0] old_q;
	logic signed [NUM_W-1:0] num_q;
	logic [31:0]        sq_q;
	logic signed [WIDE_W-1:0] r_q;
	logic [31:0]        root_q;

	// output register
	logic               out_vld_q;
	logic [PT_W-1:0]    out_idx_q;
	logic [31:0]        out_vel_q;
	logic               out_last_q;

	// stores
	logic [31:0] vel_mem [MAX_POINTS];
	logic [31:0] cor_mem [MAX_POINTS];
	logic [31:0] rhs_mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] vel_vld_q;
	logic [MAX_POINTS-1:0] cor_vld_q;
	logic [31:0] vel_rdata_q, cor_rdata_q, rhs_rdata_q;
	logic        vel_rvld_q, cor_rvld_q;
	logic [PT_W-1:0] vel_raddr, cor_raddr, vel_waddr;
	logic        vel_we, cor_we, rhs_we;
	logic [31:0] vel_wdata;
	logic signed [31:0] vel_rd, cor_rd, rhs_rd;

	// shared units
	logic              mac_start, mac_neg, mac_done;
	mac_mode_t         mac_mode;
	logic [31:0]       mac_a;
	logic [COEF_W-1:0] mac_c;
	logic [63:0]       mac_res;
	logic signed [WIDE_W-1:0] mres;
	logic              div_start, div_done;
	logic signed [31:0] div_quo;
	logic              sqrt_start, sqrt_done;
	logic [31:0]       sqrt_root;
	logic [63:0]       err_n, rsum_n;

	logic [PT_W-1:0]   nm1, nm2;
	logic              s_acc;
	logic signed [31:0] acc_sat;
	logic [CNT_W-1:0]  n_clamp;
	logic signed [WIDE_W-1:0] num_w;

	assign nm1     = PT_W'(n_q - 7'd1);
	assign nm2     = PT_W'(n_q - 7'd2);
	assign s_tready = (st_q == ST_IDLE);
	assign s_acc   = s_tvalid && s_tready;
	assign vel_rd  = vel_rvld_q ? vel_rdata_q : 32'sd0;
	assign cor_rd  = cor_rvld_q ? cor_rdata_q : 32'sd0;
	assign rhs_rd  = rhs_rdata_q;
	assign mres    = mac_res[WIDE_W-1:0];
	assign acc_sat = sat32(WIDE_W'(acc_q));
	assign err_n   = sat_add64(err_q, mac_res);
	assign rsum_n  = sat_add64(rsum_q, mac_res);
	assign num_w   = WIDE_W'(rhs_rd) + mres;
	assign n_clamp = (points_q < MIN_POINTS) ? MIN_POINTS
	               : ((points_q > TOP_POINTS) ? TOP_POINTS : points_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q  <= 32'd16777216;
			theta_q  <= 17'd32768;
			points_q <= 7'd64;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SIGMA:  sigma_q  <= cfg_data;
				REG_THETA:  theta_q  <= cfg_data[THETA_W-1:0];
				REG_POINTS: points_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// store addressing
	always_comb begin
		vel_raddr = i_q;
		cor_raddr = i_q;
		case (st_q)
			ST_RHS_RD0: vel_raddr = i_q - 6'd1;
			ST_RHS_RD2: vel_raddr = i_q + 6'd1;
			default: ;
		endcase
		case (st_q)
			ST_NB_RD0: cor_raddr = i_q - 6'd1;
			ST_NB_RD1: cor_raddr = i_q + 6'd1;
			default: ;
		endcase
		vel_we    = 1'b0;
		vel_waddr = i_q;
		vel_wdata = sat32(WIDE_W'(vel_rd) + WIDE_W'(cor_rd));
		if (s_acc && (s_tuser == OP_LOAD)) begin
			vel_we    = 1'b1;
			vel_waddr = s_tdata[5:0];
			vel_wdata = s_tdata[37:6];
		end else if (st_q == ST_UP_WR) begin
			vel_we = 1'b1;
		end
		cor_we = (st_q == ST_SW_WDIV) && div_done;
		rhs_we = (st_q == ST_RHS_WAIT) && mac_done;
	end

	always_ff @(posedge clk) begin
		if (vel_we)
			vel_mem[vel_waddr] <= vel_wdata;
		vel_rdata_q <= vel_mem[vel_raddr];
	end

	always_ff @(posedge clk) begin
		if (cor_we)
			cor_mem[i_q] <= div_quo;
		cor_rdata_q <= cor_mem[cor_raddr];
	end

	always_ff @(posedge clk) begin
		if (rhs_we)
			rhs_mem[i_q] <= sat32(mres);
		rhs_rdata_q <= rhs_mem[i_q];
	end

	// valid bits stand in for the all-zero reset of the velocity and correction stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_vld_q  <= '0;
			cor_vld_q  <= '0;
			vel_rvld_q <= 1'b0;
			cor_rvld_q <= 1'b0;
		end else begin
			if (vel_we)
				vel_vld_q[vel_waddr] <= 1'b1;
			if (cor_we)
				cor_vld_q[i_q] <= 1'b1;
			vel_rvld_q <= vel_vld_q[vel_raddr];
			cor_rvld_q <= cor_vld_q[cor_raddr];
		end
	end

	// operand selection for the shared units
	always_comb begin
		mac_start = 1'b0;
		mac_mode  = MAC_Q24;
		mac_a     = abs32(acc_sat);
		mac_neg   = acc_sat[31];
		mac_c     = {3'd0, sigma_q};
		case (st_q)
			ST_TS_MUL: begin
				mac_start = 1'b1;
				mac_mode  = MAC_RAW;
				mac_a     = {15'd0, th_q};
			end
			ST_RHS_MUL: mac_start = 1'b1;
			ST_SW_MUL, ST_RS_M1: begin
				mac_start = 1'b1;
				mac_c     = {2'd0, ts_q};
			end
			ST_RS_M2: begin
				mac_start = 1'b1;
				mac_a     = abs32(old_q);
				mac_neg   = old_q[31];
				mac_c     = diag_q;
			end
			ST_SW_SQ: begin
				mac_start = 1'b1;
				mac_mode  = MAC_RAW;
				mac_a     = sq_q;
				mac_c     = {3'd0, sq_q};
			end
			ST_RS_SQ: begin
				mac_start = 1'b1;
				mac_mode  = MAC_RAW;
				mac_a     = mag_clamp32(r_q);
				mac_c     = {3'd0, mag_clamp32(r_q)};
			end
			default: ;
		endcase
		div_start  = (st_q == ST_SW_DIV);
		sqrt_start = (st_q == ST_RS_WSQ) && mac_done && (i_q == nm2);
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			n_q        <= 7'd64;
			th_q       <= '0;
			ts_q       <= '0;
			diag_q     <= '0;
			i_q        <= '0;
			sweep_q    <= '0;
			resid_q    <= 1'b0;
			err_q      <= '0;
			rsum_q     <= '0;
			acc_q      <= '0;
			old_q      <= '0;
			num_q      <= '0;
			sq_q       <= '0;
			r_q        <= '0;
			root_q     <= '0;
			out_vld_q  <= 1'b0;
			out_idx_q  <= '0;
			out_vel_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser == OP_STEP)) begin
						n_q  <= n_clamp;
						th_q <= (theta_q > THETA_ONE) ? THETA_ONE : theta_q;
						st_q <= ST_TS_MUL;
					end
				end
				ST_TS_MUL: st_q <= ST_TS_WAIT;
				ST_TS_WAIT: begin
					if (mac_done) begin
						ts_q   <= 33'((mac_res[48:0] + 49'd32768) >> 16);
						diag_q <= ONE_Q24 + {1'b0, mac_res[48:16] + {32'd0, mac_res[15]}, 1'b0};
						i_q    <= 6'd1;
						st_q   <= ST_RHS_RD0;
					end
				end
				// right-hand side: sigma times the Laplacian of the stored velocity
				ST_RHS_RD0: st_q <= ST_RHS_RD1;
				ST_RHS_RD1: begin
					acc_q <= 35'(vel_rd);
					st_q  <= ST_RHS_RD2;
				end
				ST_RHS_RD2: begin
					acc_q <= acc_q - (35'(vel_rd) <<< 1);
					st_q  <= ST_RHS_RD3;
				end
				ST_RHS_RD3: begin
					acc_q <= acc_q + 35'(vel_rd);
					st_q  <= ST_RHS_MUL;
				end
				ST_RHS_MUL: st_q <= ST_RHS_WAIT;
				ST_RHS_WAIT: begin
					if (mac_done) begin
						if (i_q == nm2) begin
							sweep_q <= '0;
							err_q   <= '0;
							resid_q <= 1'b0;
							st_q    <= ST_NB_RD0;
						end else begin
							i_q  <= i_q + 6'd1;
							st_q <= ST_RHS_RD0;
						end
					end
				end
				// neighbour sum of the corrections, shared by sweeps and residual
				ST_NB_RD0: st_q <= ST_NB_RD1;
				ST_NB_RD1: begin
					acc_q <= (i_q == 6'd1) ? 35'sd0 : 35'(cor_rd);
					st_q  <= ST_NB_RD2;
				end
				ST_NB_RD2: begin
					if (i_q != nm2)
						acc_q <= acc_q + 35'(cor_rd);
					st_q <= ST_NB_RD3;
				end
				ST_NB_RD3: begin
					old_q <= cor_rd;
					st_q  <= resid_q ? ST_RS_M1 : ST_SW_MUL;
				end
				// one Gauss-Seidel point update
				ST_SW_MUL: st_q <= ST_SW_WMUL;
				ST_SW_WMUL: begin
					if (mac_done) begin
						if (num_w > NUM_LIMIT)
							num_q <= NUM_LIMIT[NUM_W-1:0];
						else if (num_w < -NUM_LIMIT)
							num_q <= -NUM_LIMIT[NUM_W-1:0];
						else
							num_q <= num_w[NUM_W-1:0];
						st_q <= ST_SW_DIV;
					end
				end
				ST_SW_DIV: st_q <= ST_SW_WDIV;
				ST_SW_WDIV: begin
					if (div_done) begin
						sq_q <= mag_clamp32(WIDE_W'(div_quo) - WIDE_W'(old_q));
						st_q <= ST_SW_SQ;
					end
				end
				ST_SW_SQ: st_q <= ST_SW_WSQ;
				ST_SW_WSQ: begin
					if (mac_done) begin
						if (i_q == 6'd1) begin
							if ((err_n <= CONV_LIMIT) ||
							    (sweep_q == SWEEP_W'(MAX_SWEEPS - 1))) begin
								st_q <= ST_UP_RD;
							end else begin
								sweep_q <= sweep_q + 3'd1;
								err_q   <= '0;
								i_q     <= nm2;
								st_q    <= ST_NB_RD0;
							end
						end else begin
							err_q <= err_n;
							i_q   <= i_q - 6'd1;
							st_q  <= ST_NB_RD0;
						end
					end
				end
				// apply the correction to the interior
				ST_UP_RD: st_q <= ST_UP_WR;
				ST_UP_WR: begin
					if (i_q == nm2) begin
						i_q     <= 6'd1;
						resid_q <= 1'b1;
						rsum_q  <= '0;
						st_q    <= ST_NB_RD0;
					end else begin
						i_q  <= i_q + 6'd1;
						st_q <= ST_UP_RD;
					end
				end
				// residual of the linear system
				ST_RS_M1: st_q <= ST_RS_W1;
				ST_RS_W1: begin
					if (mac_done) begin
						r_q  <= num_w;
						st_q <= ST_RS_M2;
					end
				end
				ST_RS_M2: st_q <= ST_RS_W2;
				ST_RS_W2: begin
					if (mac_done) begin
						r_q  <= r_q - mres;
						st_q <= ST_RS_SQ;
					end
				end
				ST_RS_SQ: st_q <= ST_RS_WSQ;
				ST_RS_WSQ: begin
					if (mac_done) begin
						rsum_q <= rsum_n;
						if (i_q == nm2) begin
							st_q <= ST_SQRT;
						end else begin
							i_q  <= i_q + 6'd1;
							st_q <= ST_NB_RD0;
						end
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						root_q <= sqrt_root;
						i_q    <= '0;
						st_q   <= ST_EM_RD;
					end
				end
				// emit every point through the output register
				ST_EM_RD: st_q <= ST_EM_LD;
				ST_EM_LD: begin
					out_vld_q  <= 1'b1;
					out_idx_q  <= i_q;
					out_vel_q  <= vel_rd;
					out_last_q <= (i_q == nm1);
					st_q       <= ST_EM_WAIT;
				end
				ST_EM_WAIT: begin
					if (m_tready) begin
						out_vld_q <= 1'b0;
						if (out_last_q) begin
							st_q <= ST_IDLE;
						end else begin
							i_q  <= i_q + 6'd1;
							st_q <= ST_EM_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	idgs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.mode   (mac_mode),
		.a      (mac_a),
		.c      (mac_c),
		.neg    (mac_neg),
		.done   (mac_done),
		.res    (mac_res)
	);

	idgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (diag_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	idgs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (rsum_n),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, root_q, out_vel_q, out_idx_q};
	assign m_tlast  = out_last_q;

endmodule

// File: src/idgs_mac.sv
module idgs_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  idgs_pkg::mac_mode_t           mode,
	input  logic [31:0]                   a,
	input  logic [idgs_pkg::COEF_W-1:0]   c,
	input  logic                          neg,
	output logic                          done,
	output logic [63:0]                   res
);
	import idgs_pkg::*;

	typedef enum logic [3:0] {
		MS_IDLE = 4'b0001,
		MS_LO   = 4'b0010,
		MS_HI   = 4'b0100,
		MS_ADD  = 4'b1000
	} mac_state_t;

	mac_state_t        st_q;
	logic [31:0]       a_q;
	logic [COEF_W-1:0] c_q;
	logic              neg_q;
	mac_mode_t         mode_q;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;
	logic [63:0]       prod_s1;
	logic [55:0]       lo_q;
	logic [66:0]       sum;
	logic [42:0]       rnd;
	logic [63:0]       res_q;
	logic              done_q;

	// single 32x32 multiplier: low coefficient bits, then high bits in Q24 mode
	always_comb begin
		case (st_q)
			MS_LO:   mul_b = (mode_q == MAC_RAW) ? c_q[31:0] : {8'd0, c_q[23:0]};
			MS_HI:   mul_b = {21'd0, c_q[34:24]};
			default: mul_b = '0;
		endcase
	end
	assign mul_p = {32'd0, a_q} * {32'd0, mul_b};

	// recombine partial products, round to nearest on the magnitude
	assign sum = {11'd0, lo_q} + {prod_s1[42:0], 24'd0} + 67'd8388608;
	assign rnd = sum[66:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= MS_IDLE;
			a_q     <= '0;
			c_q     <= '0;
			neg_q   <= 1'b0;
			mode_q  <= MAC_RAW;
			prod_s1 <= '0;
			lo_q    <= '0;
			res_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				MS_IDLE: begin
					if (start) begin
						a_q    <= a;
						c_q    <= c;
						neg_q  <= neg;
						mode_q <= mode;
						st_q   <= MS_LO;
					end
				end
				MS_LO: begin
					prod_s1 <= mul_p;
					st_q    <= (mode_q == MAC_RAW) ? MS_ADD : MS_HI;
				end
				MS_HI: begin
					lo_q    <= prod_s1[55:0];
					prod_s1 <= mul_p;
					st_q    <= MS_ADD;
				end
				MS_ADD: begin
					if (mode_q == MAC_RAW)
						res_q <= prod_s1;
					else if (neg_q)
						res_q <= 64'd0 - {21'd0, rnd};
					else
						res_q <= {21'd0, rnd};
					done_q <= 1'b1;
					st_q   <= MS_IDLE;
				end
				default: st_q <= MS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: src/idgs_div.sv
module idgs_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [idgs_pkg::NUM_W-1:0]  num,
	input  logic [idgs_pkg::COEF_W-1:0]        den,
	output logic                               done,
	output logic signed [31:0]                 quo
);
	import idgs_pkg::*;

	localparam int DVD_W = 63;
	localparam logic [5:0] LAST_STEP = 6'(DVD_W - 1);

	logic              busy_q;
	logic [5:0]        cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [COEF_W-1:0] rem_q;
	logic [COEF_W-1:0] den_q;
	logic              neg_q;
	logic              done_q;
	logic signed [31:0] quo_q;
	logic [NUM_W-1:0]  mag;
	logic [COEF_W:0]   shifted;
	logic              ge;
	logic [COEF_W:0]   rem_n;
	logic [DVD_W-1:0]  qfin;

	assign mag     = num[NUM_W-1] ? (40'd0 - num) : num;
	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign rem_n   = ge ? (shifted - {1'b0, den_q}) : shifted;
	assign qfin    = {dvd_q[DVD_W-2:0], ge};

	// restoring division, one quotient bit a cycle; dividend carries +den/2 for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			neg_q  <= 1'b0;
			done_q <= 1'b0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					dvd_q  <= {mag[38:0], 24'd0} + {29'd0, den[COEF_W-1:1]};
					rem_q  <= '0;
					den_q  <= den;
					neg_q  <= num[NUM_W-1];
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else begin
				rem_q <= rem_n[COEF_W-1:0];
				dvd_q <= qfin;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (neg_q)
						quo_q <= (qfin > 63'd2147483648) ? 32'sh8000_0000
						                                 : (32'd0 - qfin[31:0]);
					else
						quo_q <= (qfin > 63'd2147483647) ? 32'sh7FFF_FFFF : qfin[31:0];
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: src/idgs_sqrt.sv
module idgs_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);
	import idgs_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'd31;

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic        done_q;
	logic [33:0] rem_s;
	logic [33:0] trial;
	logic        ge;
	logic [33:0] rem_n;

	assign rem_s = {rem_q[31:0], x_q[63:62]};
	assign trial = {root_q, 2'b01};
	assign ge    = rem_s >= trial;
	assign rem_n = ge ? (rem_s - trial) : rem_s;

	// digit-by-digit square root, two radicand bits a cycle, rounded down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					x_q    <= x;
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else begin
				x_q    <= {x_q[61:0], 2'b00};
				rem_q  <= rem_n[32:0];
				root_q <= {root_q[30:0], ge};
				cnt_q  <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import idgs_pkg::*;

	localparam int    CYCLE_LIMIT = 40000000;
	localparam int    SETTLE      = 64;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [PT_W-1:0] idx;
		logic [31:0]     vel;
		logic [31:0]     res;
		logic            last;
	} point_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [5:0] point_index, [37:6] value, [39:38] zero
	logic        s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [5:0] out_index, [37:6] velocity, [69:38] residual
	logic        m_tlast;
	logic        cfg_wen;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// shadow of the block's registers and stores
	longint unsigned sigma_q24;
	longint unsigned theta_q16;
	int              pts_cfg;
	int              vel_mem  [MAX_POINTS];
	int              corr_mem [MAX_POINTS];
	int              rhs_mem  [MAX_POINTS];

	point_result_t   pending_points[$];
	int              tx_idle_pct;
	int              rx_idle_pct;
	int              error_count;
	int              cycle_count;
	int              loads_sent;
	int              steps_sent;
	int              points_checked;

	implicit_diffusion_step_gauss_seidel i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// starts low so that no rising edge falls at time zero
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// fixed-point helpers
	function automatic longint clamp_i32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_shr24(longint v);
		longint unsigned m;
		longint unsigned r;
		m = (v < 0) ? longint'(-v) : v;
		r = (m + 64'd8388608) >> 24;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint q24_scale(longint unsigned c, longint x);
		longint hi;
		longint lo;
		hi = longint'(c >> 24);
		lo = longint'(c & 64'hFF_FFFF);
		return x * hi + round_shr24(x * lo);
	endfunction

	function automatic longint round_quot(longint num, longint unsigned d);
		longint unsigned m;
		longint unsigned q;
		m = (num < 0) ? longint'(-num) : num;
		q = (m + d / 2) / d;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned sq_mag(longint v);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : v;
		if (m > 64'hFFFF_FFFF)
			m = 64'hFFFF_FFFF;
		return m * m;
	endfunction

	function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
		if (a > ~64'd0 - b)
			return ~64'd0;
		return a + b;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// boundary corrections always read as zero
	function automatic longint corr_or_zero(int i, int n);
		if (i == 0 || i >= n - 1)
			return 0;
		return corr_mem[i];
	endfunction

	// one implicit time step; queues one result per mesh point
	task automatic predict_time_step();
		int              n;
		longint unsigned th;
		longint unsigned ts;
		longint unsigned diag;
		longint unsigned upd_sq;
		longint unsigned res_sq;
		longint          lap;
		longint          nb;
		longint          num;
		longint          r;
		int              fresh;
		point_result_t   pr;
		n = pts_cfg;
		if (n < 3)
			n = 3;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		th = (theta_q16 > 65536) ? 65536 : theta_q16;
		ts = (th * sigma_q24 + 32768) >> 16;
		diag = 64'd16777216 + 2 * ts;
		for (int i = 1; i < n - 1; i++) begin
			lap = longint'(vel_mem[i+1]) - 2 * longint'(vel_mem[i]) + longint'(vel_mem[i-1]);
			rhs_mem[i] = int'(clamp_i32(q24_scale(sigma_q24, clamp_i32(lap))));
		end
		// backward sweeps with early exit on a small update
		for (int sw = 0; sw < MAX_SWEEPS; sw++) begin
			upd_sq = 0;
			for (int i = n - 2; i > 0; i--) begin
				nb = clamp_i32(corr_or_zero(i - 1, n) + corr_or_zero(i + 1, n));
				num = longint'(rhs_mem[i]) + q24_scale(ts, nb);
				if (num > 64'sd274877906944)
					num = 64'sd274877906944;
				if (num < -64'sd274877906944)
					num = -64'sd274877906944;
				fresh = int'(clamp_i32(round_quot(num * 64'sd16777216, diag)));
				upd_sq = add_sat(upd_sq, sq_mag(longint'(fresh) - longint'(corr_mem[i])));
				corr_mem[i] = fresh;
			end
			if (upd_sq <= 64'd4294)
				break;
		end
		for (int i = 1; i < n - 1; i++)
			vel_mem[i] = int'(clamp_i32(longint'(vel_mem[i]) + longint'(corr_mem[i])));
		res_sq = 0;
		for (int i = 1; i < n - 1; i++) begin
			nb = clamp_i32(corr_or_zero(i - 1, n) + corr_or_zero(i + 1, n));
			r = longint'(rhs_mem[i]) - q24_scale(diag, corr_mem[i]) + q24_scale(ts, nb);
			res_sq = add_sat(res_sq, sq_mag(r));
		end
		res_sq = floor_sqrt(res_sq);
		for (int i = 0; i < n; i++) begin
			pr.idx  = i[PT_W-1:0];
			pr.vel  = vel_mem[i];
			pr.res  = res_sq[31:0];
			pr.last = (i == n - 1);
			pending_points.push_back(pr);
		end
	endtask

	// one input transaction, sometimes after a random gap
	task automatic send_item(opcode_t op, logic [PT_W-1:0] pt, logic [31:0] val);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, val, pt};
		do
			@(posedge clk);
		while (!s_tready);
		if (op == OP_LOAD) begin
			vel_mem[pt] = val;
			loads_sent++;
		end else begin
			predict_time_step();
			steps_sent++;
		end
	endtask

	// drain all results and let a trailing load settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		wait_idle();
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_SIGMA:  sigma_q24 = val;
			REG_THETA:  theta_q16 = val[THETA_W-1:0];
			REG_POINTS: pts_cfg   = val[CNT_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_velocity();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'($signed($urandom_range(2097152)) - 1048576);
			default: return 32'($signed($urandom_range(131072)) - 65536);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		point_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result idx %0d", $time, m_tdata[5:0]);
				error_count++;
			end else begin
				want = pending_points.pop_front();
				points_checked++;
				if (m_tdata[5:0] !== want.idx) begin
					$display("%0t: out_index exp %0d act %0d", $time, want.idx, m_tdata[5:0]);
					error_count++;
				end
				if (m_tdata[37:6] !== want.vel) begin
					$display("%0t: velocity[%0d] exp %h act %h", $time, want.idx, want.vel,
						m_tdata[37:6]);
					error_count++;
				end
				if (m_tdata[69:38] !== want.res) begin
					$display("%0t: residual[%0d] exp %h act %h", $time, want.idx, want.res,
						m_tdata[69:38]);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last[%0d] exp %b act %b", $time, want.idx, want.last,
						m_tlast);
					error_count++;
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("implicit_diffusion_step_gauss_seidel test failed");
			$finish;
		end
	end

	// step from reset values, full mesh of zeros
	task automatic test_reset_step();
		send_item(OP_STEP, 6'd0, 32'd0);
	endtask

	// value extremes with extreme coefficients
	task automatic test_extremes();
		write_reg(REG_POINTS, 32'd5);
		write_reg(REG_SIGMA, 32'hFFFF_FFFF);
		write_reg(REG_THETA, 32'd0);
		send_item(OP_LOAD, 6'd0, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 6'd2, 32'h8000_0000);
		send_item(OP_LOAD, 6'd4, 32'h8000_0000);
		send_item(OP_LOAD, 6'd3, 32'h7FFF_FFFF);
		send_item(OP_STEP, 6'd0, 32'd0);
		write_reg(REG_THETA, 32'd65536);
		send_item(OP_STEP, 6'd0, 32'd0);
		write_reg(REG_SIGMA, 32'd0);
		send_item(OP_STEP, 6'd0, 32'd0);
	endtask

	// clamped theta and point counts, stale boundary corrections
	task automatic test_clamps();
		write_reg(REG_SIGMA, 32'h0180_0000);
		write_reg(REG_THETA, 32'h1_FFFF);
		write_reg(REG_POINTS, 32'd0);
		send_item(OP_LOAD, 6'd1, 32'h0003_0000);
		send_item(OP_STEP, 6'd0, 32'd0);
		write_reg(REG_POINTS, 32'd127);
		send_item(OP_LOAD, 6'd63, 32'hFFFE_0000);
		send_item(OP_LOAD, 6'd40, 32'h0010_0000);
		send_item(OP_STEP, 6'd0, 32'd0);
		write_reg(REG_POINTS, 32'd8);
		send_item(OP_LOAD, 6'd50, 32'h0000_1234);
		send_item(OP_STEP, 6'd0, 32'd0);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_item(OP_STEP, 6'd0, 32'd0);
	endtask

	// random coefficients and traffic under one idling pattern
	task automatic test_random_phase(int tx_pct, int rx_pct, int items);
		int n;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int k = 0; k < items; k++) begin
			if (k % 25 == 0) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 10);
				write_reg(REG_POINTS, n);
				write_reg(REG_SIGMA, ($urandom_range(3) == 0) ? $urandom :
					$urandom_range(33554432));
				write_reg(REG_THETA, ($urandom_range(4) == 0) ? $urandom_range(131071) :
					$urandom_range(65536));
			end
			if ($urandom_range(99) < 20)
				send_item(OP_STEP, 6'($urandom), $urandom);
			else if ($urandom_range(9) == 0)
				send_item(OP_LOAD, 6'($urandom_range(63)), pick_velocity());
			else
				send_item(OP_LOAD, 6'($urandom_range(n - 1)), pick_velocity());
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= 1'b0;
		cfg_wen     <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		m_tready    <= 1'b0;
		sigma_q24   = 16777216;
		theta_q16   = 32768;
		pts_cfg     = 64;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		error_count = 0;
		cycle_count = 0;
		loads_sent  = 0;
		steps_sent  = 0;
		points_checked = 0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			vel_mem[i]  = 0;
			corr_mem[i] = 0;
			rhs_mem[i]  = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 12;
		rx_idle_pct = 79;
		test_reset_step();
		test_extremes();
		test_clamps();
		test_random_phase(12, 79, 105);
		test_random_phase(79, 12, 105);
		test_random_phase(0, 0, 110);
		wait_idle();

		$display("Covered %0d point loads and %0d time steps, %0d mesh points checked,",
			loads_sent, steps_sent, points_checked);
		$display("with clamped coefficients, point counts 3 to 64 and mixed back-pressure.");
		if (error_count == 0)
			$display("implicit_diffusion_step_gauss_seidel test passed");
		else
			$display("implicit_diffusion_step_gauss_seidel test failed");
		$finish;
	end

endmodule
